@@ hdl/damerau_levenshtein_distance_core_assert.svh @@
// Assertion macros shared by the distance core modules.
`ifndef DAMERAU_LEVENSHTEIN_DISTANCE_CORE_ASSERT_SVH
`define DAMERAU_LEVENSHTEIN_DISTANCE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define DLD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define DLD_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define DLD_ASSERT(label, clk, rst_n, prop)
`define DLD_ASSERT_NR(label, clk, prop)
`endif
`endif

@@ hdl/dld_pkg.sv @@
package dld_pkg;
    localparam int MaxLen   = 64;
    localparam int Alphabet = 128;
    localparam int Stride   = MaxLen + 2;
    localparam int Cells    = Stride * Stride;
    localparam int LenW     = $clog2(MaxLen + 1);
    localparam int IdxW     = $clog2(MaxLen + 2);
    localparam int PosW     = $clog2(MaxLen);
    localparam int AddrW    = $clog2(Cells);
    localparam int CostW    = 8;
    localparam int SymW     = 7;
    localparam int AlphaW   = $clog2(Alphabet);

    typedef logic [IdxW-1:0]  t_idx;
    typedef logic [CostW-1:0] t_cost;
    typedef logic [AddrW-1:0] t_addr;

    function automatic t_addr cell_addr(input t_idx r, input t_idx c);
        logic [AddrW+IdxW-1:0] p;
        begin
            p = AddrW'(r) * (AddrW+IdxW)'(Stride) + (AddrW+IdxW)'(c);
            return p[AddrW-1:0];
        end
    endfunction
endpackage

@@ hdl/dld_ram.sv @@
module dld_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ hdl/dld_engine.sv @@
`include "damerau_levenshtein_distance_core_assert.svh"
module dld_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [dld_pkg::LenW-1:0] i_n,
    input  logic [dld_pkg::LenW-1:0] i_m,
    output logic [dld_pkg::PosW-1:0] o_a_addr,
    input  logic [dld_pkg::SymW-1:0] i_a_sym,
    output logic [dld_pkg::PosW-1:0] o_b_addr,
    input  logic [dld_pkg::SymW-1:0] i_b_sym,
    output logic                 o_done,
    output logic [dld_pkg::CostW-1:0] o_dist
);
    import dld_pkg::*;

    // Each inner cell steps through a symbol fetch (S_SYM), four reads of the cost memory
    // (S_R0 to S_R3), then the write (S_WR).
    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_BORD, S_ROWA, S_SYM, S_R0, S_R1, S_R2, S_R3, S_WR,
        S_ROWEND, S_FIN0, S_FIN1
    } t_state;

    t_state r_state;
    t_idx   r_i, r_j, r_k, r_l, r_lim;
    t_cost  r_inf, r_best, r_diag;
    logic [SymW-1:0] r_a;
    logic [AlphaW-1:0] r_clr;
    logic r_bph;
    logic r_match;

    // Per-symbol row memory; an epoch-free clear sweep runs at each start.
    logic            sym_we;
    logic [AlphaW-1:0] sym_waddr, sym_raddr;
    t_idx            sym_wdata, sym_rdata;
    logic            cost_we;
    t_addr           cost_waddr, cost_raddr;
    t_cost           cost_wdata, cost_rdata;

    dld_ram #(.Width(IdxW), .Depth(Alphabet)) u_sym (
        .i_clk(i_clk), .i_we(sym_we), .i_waddr(sym_waddr), .i_wdata(sym_wdata),
        .i_raddr(sym_raddr), .o_rdata(sym_rdata));
    dld_ram #(.Width(CostW), .Depth(Cells)) u_cost (
        .i_clk(i_clk), .i_we(cost_we), .i_waddr(cost_waddr), .i_wdata(cost_wdata),
        .i_raddr(cost_raddr), .o_rdata(cost_rdata));

    logic [CostW:0] trans_sum;
    t_cost cand;
    logic [SymW-1:0] b_sym;
    assign b_sym = i_b_sym;

    always_comb begin
        trans_sum = (CostW+1)'(r_i) - (CostW+1)'(r_k) + (CostW+1)'(r_j)
                  - (CostW+1)'(r_l) - (CostW+1)'(1);
        cand = '0;
        sym_we = 1'b0; sym_waddr = r_clr; sym_wdata = t_idx'(1);
        sym_raddr = b_sym[AlphaW-1:0];
        cost_we = 1'b0; cost_waddr = '0; cost_wdata = '0; cost_raddr = '0;
        o_a_addr = PosW'(r_i - t_idx'(2));
        o_b_addr = PosW'(r_j - t_idx'(2));
        unique case (r_state)
            S_CLR: begin
                sym_we = 1'b1;
            end
            S_BORD: begin
                cost_we = 1'b1;
                if (!r_bph) begin
                    // Left border, column zero and one of row r_j.
                    cost_waddr = cell_addr(r_j, r_l);
                    cost_wdata = (r_l == '0 || r_j == '0) ? r_inf : t_cost'(r_j - t_idx'(1));
                end else begin
                    cost_waddr = cell_addr(r_l, r_j);
                    cost_wdata = (r_l == '0 || r_j == '0) ? r_inf : t_cost'(r_j - t_idx'(1));
                end
            end
            S_R0: cost_raddr = cell_addr(r_i - t_idx'(1), r_j - t_idx'(1));
            S_R1: cost_raddr = cell_addr(r_i, r_j - t_idx'(1));
            S_R2: cost_raddr = cell_addr(r_i - t_idx'(1), r_j);
            S_R3: cost_raddr = cell_addr(r_k - t_idx'(1), r_l - t_idx'(1));
            S_WR: begin
                cand = t_cost'(cost_rdata + trans_sum[CostW-1:0]);
                cost_we = 1'b1;
                cost_waddr = cell_addr(r_i, r_j);
                cost_wdata = (cand < r_best) ? cand : r_best;
            end
            S_ROWEND: begin
                sym_we = ({1'b0, r_a} < (SymW+1)'(Alphabet));
                sym_waddr = r_a[AlphaW-1:0];
                sym_wdata = r_i;
            end
            S_FIN0: cost_raddr = cell_addr(t_idx'(i_n) + t_idx'(1), t_idx'(i_m) + t_idx'(1));
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_start) begin
                    r_inf <= t_cost'(i_n) + t_cost'(i_m);
                    r_clr <= '0;
                    r_state <= S_CLR;
                end
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AlphaW'(Alphabet - 1)) begin
                        r_bph <= 1'b0; r_j <= '0; r_l <= '0;
                        r_lim <= t_idx'(i_n) + t_idx'(1);
                        r_state <= S_BORD;
                    end
                end
                S_BORD: begin
                    // r_l walks 0 then 1; r_j walks the border index.
                    if (r_l == '0) begin
                        r_l <= t_idx'(1);
                    end else begin
                        r_l <= '0;
                        if (r_j == r_lim) begin
                            if (!r_bph) begin
                                r_bph <= 1'b1; r_j <= '0;
                                r_lim <= t_idx'(i_m) + t_idx'(1);
                            end else begin
                                r_i <= t_idx'(2);
                                r_state <= (i_n == '0 || i_m == '0) ? S_FIN0 : S_ROWA;
                            end
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
                S_ROWA: begin
                    r_j <= t_idx'(2);
                    r_l <= t_idx'(1);
                    r_state <= S_SYM;
                end
                S_SYM: begin
                    // Symbol RAMs return a and b for the current cell.
                    r_a <= i_a_sym;
                    r_state <= S_R0;
                end
                S_R0: begin
                    r_match <= (r_a == b_sym);
                    r_state <= S_R1;
                end
                S_R1: begin
                    // The row table read is registered: it answers for b in the cycle after it was addressed.
                    r_k <= ({1'b0, b_sym} < (SymW+1)'(Alphabet)) ? sym_rdata : t_idx'(1);
                    r_diag <= cost_rdata + (r_match ? t_cost'(0) : t_cost'(1));
                    r_state <= S_R2;
                end
                S_R2: begin
                    r_best <= ((cost_rdata + 1'b1) < r_diag) ? cost_rdata + 1'b1 : r_diag;
                    r_state <= S_R3;
                end
                S_R3: begin
                    if ((cost_rdata + 1'b1) < r_best) r_best <= cost_rdata + 1'b1;
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (r_match) r_l <= r_j;
                    if (r_j == t_idx'(i_m) + t_idx'(1)) begin
                        r_state <= S_ROWEND;
                    end else begin
                        r_j <= r_j + 1'b1;
                        r_state <= S_SYM;
                    end
                end
                S_ROWEND: begin
                    if (r_i == t_idx'(i_n) + t_idx'(1)) begin
                        r_state <= S_FIN0;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_ROWA;
                    end
                end
                S_FIN0: r_state <= S_FIN1;
                S_FIN1: begin
                    o_dist <= cost_rdata;
                    o_done <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `DLD_ASSERT(a_start_idle, i_clk, i_rst_n, i_start |-> r_state == S_IDLE)
    `DLD_ASSERT(a_done_after_fin, i_clk, i_rst_n, o_done |-> $past(r_state) == S_FIN1)
    `DLD_ASSERT(a_write_in_table, i_clk, i_rst_n,
        r_state == S_WR |-> (r_i <= t_idx'(i_n) + t_idx'(1) && r_j <= t_idx'(i_m) + t_idx'(1)))
endmodule

@@ hdl/damerau_levenshtein_distance_core.sv @@
// Damerau-Levenshtein distance core (unrestricted, unit costs).
// Input channel: i_valid/o_stall with string_select, symbol, has_symbol and
// end_of_pair. A word with has_symbol appends the symbol to string 0 or 1,
// at most 64 symbols each; extra symbols are dropped and flag too_long.
// A word with end_of_pair (after its symbol, if any) starts the computation.
// Output channel: o_valid/i_stall with distance and too_long, one word per
// end_of_pair. Loading takes one word per cycle while o_stall is low. A
// computation clears the 128-entry symbol table, writes the borders, then
// walks the rows of the first string, where each table cell needs a symbol
// fetch, four reads of the single cost port and one write; last it fetches
// the result. A too_long pair answers at once.
// o_stall is high while a computation runs or a result waits unread.
// The synchronous reset clears lengths, the overflow flag and all handshake
// state; string and cost memories are not cleared. While i_stall is high a
// waiting result word holds and no new word is accepted.
`include "damerau_levenshtein_distance_core_assert.svh"
module damerau_levenshtein_distance_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_string_select,
    input  logic [6:0] i_symbol,
    input  logic       i_has_symbol,
    input  logic       i_end_of_pair,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_distance,
    output logic       o_too_long
);
    import dld_pkg::*;

    logic [LenW-1:0] r_n, r_m;
    logic r_ovf, r_busy;
    logic [SymW-1:0] r_ta [MaxLen];
    logic [SymW-1:0] r_tb [MaxLen];
    logic [SymW-1:0] r_a_q, r_b_q;
    logic [PosW-1:0] a_addr, b_addr;
    logic acc, start, done;
    logic [LenW-1:0] n_n, n_m;
    logic n_ovf;
    t_cost eng_dist;

    assign o_stall = r_busy || o_valid;
    assign acc = i_valid && !o_stall;

    always_comb begin
        n_n = r_n; n_m = r_m; n_ovf = r_ovf;
        if (acc && i_has_symbol) begin
            if (!i_string_select) begin
                if (r_n < LenW'(MaxLen)) n_n = r_n + 1'b1; else n_ovf = 1'b1;
            end else begin
                if (r_m < LenW'(MaxLen)) n_m = r_m + 1'b1; else n_ovf = 1'b1;
            end
        end
    end
    assign start = acc && i_end_of_pair && !n_ovf;

    always_ff @(posedge i_clk) begin
        if (acc && i_has_symbol && !i_string_select && r_n < LenW'(MaxLen))
            r_ta[r_n[PosW-1:0]] <= i_symbol;
        if (acc && i_has_symbol && i_string_select && r_m < LenW'(MaxLen))
            r_tb[r_m[PosW-1:0]] <= i_symbol;
        r_a_q <= r_ta[a_addr];
        r_b_q <= r_tb[b_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0; r_m <= '0; r_ovf <= 1'b0; r_busy <= 1'b0; o_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall) o_valid <= 1'b0;
            if (acc && i_end_of_pair) begin
                r_ovf <= 1'b0;
                if (n_ovf) begin
                    o_valid <= 1'b1; o_distance <= '0; o_too_long <= 1'b1;
                    r_n <= '0; r_m <= '0;
                end else begin
                    r_busy <= 1'b1; r_n <= n_n; r_m <= n_m;
                end
            end else if (acc) begin
                r_n <= n_n; r_m <= n_m; r_ovf <= n_ovf;
            end
            if (done) begin
                r_busy <= 1'b0; o_valid <= 1'b1;
                o_distance <= eng_dist; o_too_long <= 1'b0;
                r_n <= '0; r_m <= '0;
            end
        end
    end

    dld_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_n(n_n), .i_m(n_m),
        .o_a_addr(a_addr), .i_a_sym(r_a_q), .o_b_addr(b_addr), .i_b_sym(r_b_q),
        .o_done(done), .o_dist(eng_dist));

    `DLD_ASSERT(a_done_busy, i_clk, i_rst_n, done |-> r_busy)
    `DLD_ASSERT(a_no_acc_busy, i_clk, i_rst_n, r_busy |-> !acc)
    `DLD_ASSERT(a_len_bound, i_clk, i_rst_n, r_n <= LenW'(MaxLen) && r_m <= LenW'(MaxLen))
endmodule

@@ tb/tb_damerau_levenshtein_distance_core.sv @@
`timescale 1ns / 100ps

module tb_damerau_levenshtein_distance_core;

    localparam int MaxLen = dld_pkg::MaxLen;
    localparam int Alphabet = dld_pkg::Alphabet;

    typedef struct packed {
        logic       sel;
        logic [6:0] sym;
        logic       has;
        logic       eop;
        logic       drain;
    } load_word_t;

    typedef struct packed {
        logic [7:0] distance;
        logic       too_long;
    } distance_word_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic       i_string_select = 1'b0;
    logic [6:0] i_symbol = '0;
    logic       i_has_symbol = 1'b0;
    logic       i_end_of_pair = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_distance;
    logic       o_too_long;

    load_word_t     load_q[$];
    distance_word_t distance_q[$];
    int unsigned    first_str[$];
    int unsigned    second_str[$];
    bit             overflow_flag = 1'b0;
    bit             word_taken = 1'b0;
    bit             errors_seen = 1'b0;
    int             accepted_cnt = 0;
    int             word_total = 0;
    int             pair_cnt = 0;

    damerau_levenshtein_distance_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_string_select(i_string_select),
        .i_symbol       (i_symbol),
        .i_has_symbol   (i_has_symbol),
        .i_end_of_pair  (i_end_of_pair),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_distance     (o_distance),
        .o_too_long     (o_too_long)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Unrestricted distance over the full table with n+m as infinity.
    function automatic int dl_distance(input int unsigned a[$], input int unsigned b[$]);
        int d[MaxLen+2][MaxLen+2];
        int last_row[Alphabet];
        int n, m, inf, k, l, db, cost, trans;
        begin
            n = a.size();
            m = b.size();
            inf = n + m;
            foreach (last_row[x]) last_row[x] = 1;
            d[0][0] = inf;
            for (int i = 1; i <= n + 1; i++) begin
                d[i][0] = inf;
                d[i][1] = i - 1;
            end
            for (int j = 1; j <= m + 1; j++) begin
                d[0][j] = inf;
                d[1][j] = j - 1;
            end
            for (int i = 2; i <= n + 1; i++) begin
                db = 1;
                for (int j = 2; j <= m + 1; j++) begin
                    k = last_row[b[j-2]];
                    l = db;
                    trans = (i - k) + (j - l) - 1;
                    cost = 1;
                    if (a[i-2] == b[j-2]) begin
                        cost = 0;
                        db = j;
                    end
                    d[i][j] = d[i-1][j-1] + cost;
                    if (d[i][j-1] + 1 < d[i][j]) d[i][j] = d[i][j-1] + 1;
                    if (d[i-1][j] + 1 < d[i][j]) d[i][j] = d[i-1][j] + 1;
                    if (d[k-1][l-1] + trans < d[i][j]) d[i][j] = d[k-1][l-1] + trans;
                end
                last_row[a[i-2]] = i;
            end
            return d[n+1][m+1];
        end
    endfunction

    function automatic void load_symbol(input load_word_t w);
        distance_word_t r;
        begin
            if (w.has) begin
                if (!w.sel) begin
                    if (first_str.size() < MaxLen) first_str.push_back(w.sym);
                    else overflow_flag = 1'b1;
                end else begin
                    if (second_str.size() < MaxLen) second_str.push_back(w.sym);
                    else overflow_flag = 1'b1;
                end
            end
            if (w.eop) begin
                if (overflow_flag) begin
                    r.distance = '0;
                    r.too_long = 1'b1;
                end else begin
                    r.distance = 8'(dl_distance(first_str, second_str));
                    r.too_long = 1'b0;
                end
                distance_q.push_back(r);
                first_str.delete();
                second_str.delete();
                overflow_flag = 1'b0;
            end
        end
    endfunction

    // Interleaves the two strings at random, sprinkles ignored words in when
    // noise is set, and sometimes carries the last symbol on the end word.
    task automatic queue_pair(input int unsigned a[$], input int unsigned b[$],
                              input bit drain, input bit noise);
        load_word_t w;
        int ia, ib;
        bit first_word;
        begin
            ia = 0;
            ib = 0;
            first_word = 1'b1;
            while (ia < a.size() || ib < b.size()) begin
                if (noise && $urandom_range(0, 99) < 5) begin
                    w = '{sel: 1'($urandom), sym: 7'($urandom), has: 1'b0,
                          eop: 1'b0, drain: drain && first_word};
                    load_q.push_back(w);
                    first_word = 1'b0;
                end
                w.has = 1'b1;
                w.drain = drain && first_word;
                if (ia < a.size() && (ib >= b.size() || $urandom_range(0, 1) == 0)) begin
                    w.sel = 1'b0;
                    w.sym = 7'(a[ia]);
                    ia++;
                end else begin
                    w.sel = 1'b1;
                    w.sym = 7'(b[ib]);
                    ib++;
                end
                w.eop = (ia == a.size() && ib == b.size() && $urandom_range(0, 1) == 0);
                load_q.push_back(w);
                word_total++;
                first_word = 1'b0;
                if (w.eop) begin
                    pair_cnt++;
                    return;
                end
            end
            w = '{sel: 1'($urandom), sym: 7'($urandom), has: 1'b0, eop: 1'b1,
                  drain: drain && first_word};
            load_q.push_back(w);
            word_total++;
            pair_cnt++;
        end
    endtask

    task automatic random_string(input int len, input bit narrow, output int unsigned s[$]);
        int unsigned base;
        begin
            s.delete();
            base = $urandom_range(0, 124);
            for (int i = 0; i < len; i++)
                s.push_back(narrow ? base + $urandom_range(0, 3) : $urandom_range(0, 127));
        end
    endtask

    // Word driver: a new word is offered only once the previous one was taken.
    always @(negedge i_clk) begin
        load_word_t w;
        bit steady;
        steady = (accepted_cnt >= 300 && accepted_cnt < 600);
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_stall <= 1'b0;
        end else begin
            i_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 37);
            if (!i_valid || word_taken) begin
                if (load_q.size() > 0 && !(load_q[0].drain && distance_q.size() > 0)
                    && (steady || $urandom_range(0, 99) >= 37)) begin
                    w = load_q.pop_front();
                    i_valid <= 1'b1;
                    i_string_select <= w.sel;
                    i_symbol <= w.sym;
                    i_has_symbol <= w.has;
                    i_end_of_pair <= w.eop;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks results against the oldest expectation, then predicts.
    always @(posedge i_clk) begin
        distance_word_t exp_w;
        load_word_t w;
        word_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (distance_q.size() == 0) begin
                    $error("unexpected result: distance %0d too_long %0d",
                           o_distance, o_too_long);
                    errors_seen = 1'b1;
                end else begin
                    exp_w = distance_q.pop_front();
                    if (o_distance !== exp_w.distance) begin
                        $error("distance: expected %0d, actual %0d",
                               exp_w.distance, o_distance);
                        errors_seen = 1'b1;
                    end
                    if (o_too_long !== exp_w.too_long) begin
                        $error("too_long: expected %0d, actual %0d",
                               exp_w.too_long, o_too_long);
                        errors_seen = 1'b1;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                w = '{sel: i_string_select, sym: i_symbol, has: i_has_symbol,
                      eop: i_end_of_pair, drain: 1'b0};
                load_symbol(w);
                accepted_cnt++;
            end
        end
    end

    initial begin
        int unsigned a[$];
        int unsigned b[$];
        int r, la, lb;
        bit narrow;

        // Directed pairs: empty strings, transpositions, extremes, overflow.
        a = {};
        b = {};
        queue_pair(a, b, 1'b0, 1'b0);
        a = {7'd0, 7'd127};
        queue_pair(a, b, 1'b0, 1'b0);
        a = {};
        b = {7'd127, 7'd0, 7'd85};
        queue_pair(a, b, 1'b0, 1'b0);
        a = {7'd97, 7'd98};
        b = {7'd98, 7'd97};
        queue_pair(a, b, 1'b1, 1'b0);
        a = {7'd99, 7'd97};
        b = {7'd97, 7'd98, 7'd99};
        queue_pair(a, b, 1'b0, 1'b1);
        a = {7'd42};
        b = {7'd42};
        queue_pair(a, b, 1'b0, 1'b0);
        random_string(MaxLen, 1'b0, a);
        b = {};
        for (int i = 0; i < MaxLen; i++) b.push_back(a[i] ^ 7'h7f);
        queue_pair(a, b, 1'b1, 1'b0);
        random_string(MaxLen + 2, 1'b1, a);
        b = {7'd5};
        queue_pair(a, b, 1'b0, 1'b0);
        random_string(MaxLen + 1, 1'b0, b);
        a = {};
        queue_pair(a, b, 1'b1, 1'b0);

        while (word_total < 1300) begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
                la = $urandom_range(MaxLen - 4, MaxLen);
                lb = $urandom_range(MaxLen - 4, MaxLen);
            end else if (r < 4) begin
                la = $urandom_range(0, MaxLen + 3);
                lb = MaxLen + 1;
            end else if (r < 14) begin
                la = $urandom_range(9, 20);
                lb = $urandom_range(9, 20);
            end else begin
                la = $urandom_range(0, 8);
                lb = $urandom_range(0, 8);
            end
            narrow = ($urandom_range(0, 99) < 70);
            random_string(la, narrow, a);
            random_string(lb, narrow, b);
            queue_pair(a, b, (pair_cnt % 20) == 0, 1'b1);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (load_q.size() > 0 || i_valid || distance_q.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (!errors_seen && distance_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(12 * 4000000);
        $display("FAIL");
        $finish;
    end

endmodule
